@@ sv/vcpm_pkg.sv @@
// Shared types, constants and register codes for the vision cone perception memory.
package vcpm_pkg;

    localparam int OBSERVERS = 32;
    localparam int ENTITIES  = 32;
    localparam int SLOTS     = OBSERVERS * ENTITIES;
    localparam int SLOT_W    = $clog2(SLOTS);

    localparam int IN_W  = 200;
    localparam int OUT_W = 136;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int DIV_STEPS = 17;

    localparam logic [16:0] CONF_ONE = 17'h10000;

    // Configuration register indexes.
    localparam logic [1:0] REG_VIEW_DISTANCE    = 2'd0;
    localparam logic [1:0] REG_AWARENESS_RADIUS = 2'd1;
    localparam logic [1:0] REG_CONE_COSINE      = 2'd2;
    localparam logic [1:0] REG_MEMORY_TICKS     = 2'd3;

    typedef struct packed {
        logic [19:0]        view_distance;
        logic [19:0]        awareness_radius;
        logic signed [15:0] cone_cosine;
        logic [15:0]        memory_ticks;
    } cfg_t;

    // Item as it travels through the front pipeline and the queue.
    typedef struct packed {
        logic              ok;
        logic              vis;
        logic [SLOT_W-1:0] slot;
        logic [4:0]        ent;
        logic [19:0]       ex;
        logic [19:0]       ey;
        logic [19:0]       sx;
        logic [19:0]       sy;
        logic [31:0]       now;
    } job_t;

    // One word of the memory table.
    typedef struct packed {
        logic        valid;
        logic [19:0] py;
        logic [19:0] px;
        logic [19:0] sy;
        logic [19:0] sx;
        logic [31:0] seen;
    } entry_t;

    typedef struct packed {
        logic [4:0]  ent;
        logic [19:0] x;
        logic [19:0] y;
        logic [19:0] sx;
        logic [19:0] sy;
        logic [16:0] conf;
        logic [31:0] seen;
    } res_t;

endpackage

@@ sv/vcpm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module vcpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds between reads.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/vcpm_front.sv @@
// Front pipeline: offsets, squared distances and the cone test, five stages.
module vcpm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [vcpm_pkg::IN_W-1:0] in_data,
    input  vcpm_pkg::cfg_t cfg,
    input  logic          hold,
    output logic          push,
    output vcpm_pkg::job_t push_job,
    input  logic          q_full
);
    import vcpm_pkg::*;

    logic en;
    logic take;
    logic [4:0] valid_reg;
    job_t job1_reg, job2_reg, job3_reg, job4_reg, job5_reg;

    // Input unpacking.
    logic [4:0]         obs, ent;
    logic signed [19:0] ox, oy, ex, ey;
    logic signed [15:0] fx, fy;
    job_t               job0;

    // Stage registers.
    logic signed [20:0] dx_reg, dy_reg;
    logic signed [15:0] fx_reg, fy_reg;
    logic [41:0]        axx_reg, ayy_reg;
    logic signed [36:0] px_reg, py_reg;
    logic [39:0]        vd2_reg, ar2_reg;
    logic [31:0]        c2_reg, c2_3_reg;
    logic               cneg_reg, cneg3_reg, cneg4_reg, cneg5_reg;
    logic               far_reg, near_reg, dotneg_reg;
    logic               far4_reg, near4_reg, dotneg4_reg;
    logic               far5_reg, near5_reg, dotneg5_reg;
    logic [41:0]        d2_reg;
    logic [36:0]        ad_reg;
    logic [35:0]        hh_reg;
    logic [36:0]        hl_reg;
    logic [37:0]        ll_reg;
    logic [52:0]        rh_reg, rl_reg;
    logic [73:0]        lhs_reg, rhs_reg;

    logic [20:0]        ax, ay;
    logic [15:0]        cmag;
    logic signed [37:0] dot;
    logic [41:0]        d2;
    logic               ge, le;

    assign obs = in_data[4:0];
    assign ent = in_data[9:5];
    assign ox  = in_data[29:10];
    assign oy  = in_data[49:30];
    assign fx  = in_data[65:50];
    assign fy  = in_data[81:66];
    assign ex  = in_data[101:82];
    assign ey  = in_data[121:102];

    always_comb
    begin
        job0      = '0;
        job0.ok   = ({4'd0, obs} < 9'(OBSERVERS)) && ({4'd0, ent} < 9'(ENTITIES));
        job0.slot = SLOT_W'(({11'd0, obs} * 16'(ENTITIES)) + {11'd0, ent});
        job0.ent  = ent;
        job0.ex   = in_data[101:82];
        job0.ey   = in_data[121:102];
        job0.sx   = in_data[141:122];
        job0.sy   = in_data[161:142];
        job0.now  = in_data[193:162];
    end

    // The whole pipeline moves together unless its last item cannot enter the queue.
    assign en       = !(valid_reg[4] && q_full);
    assign in_ready = en && !hold;
    assign take     = in_valid && in_ready;
    assign push     = valid_reg[4] && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], take};
        end
    end

    // Combinational helpers between stages.
    assign ax   = 21'(dx_reg[20] ? -dx_reg : dx_reg);
    assign ay   = 21'(dy_reg[20] ? -dy_reg : dy_reg);
    assign cmag = 16'(cfg.cone_cosine[15] ? -cfg.cone_cosine : cfg.cone_cosine);
    assign dot  = 38'(px_reg) + 38'(py_reg);
    assign d2   = axx_reg + ayy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 1: offsets of the entity from the observer.
            dx_reg   <= 21'(ex) - 21'(ox);
            dy_reg   <= 21'(ey) - 21'(oy);
            fx_reg   <= fx;
            fy_reg   <= fy;
            job1_reg <= job0;

            // Stage 2: squares, facing products and squared limits.
            axx_reg  <= 42'(ax) * 42'(ax);
            ayy_reg  <= 42'(ay) * 42'(ay);
            px_reg   <= fx_reg * dx_reg;
            py_reg   <= fy_reg * dy_reg;
            vd2_reg  <= 40'(cfg.view_distance) * 40'(cfg.view_distance);
            ar2_reg  <= 40'(cfg.awareness_radius) * 40'(cfg.awareness_radius);
            c2_reg   <= 32'(cmag) * 32'(cmag);
            cneg_reg <= cfg.cone_cosine[15];
            job2_reg <= job1_reg;

            // Stage 3: squared distance, dot product and range flags.
            d2_reg     <= d2;
            far_reg    <= d2 > {2'd0, vd2_reg};
            near_reg   <= d2 <= {2'd0, ar2_reg};
            dotneg_reg <= dot[37];
            ad_reg     <= 37'(dot[37] ? -dot : dot);
            c2_3_reg   <= c2_reg;
            cneg3_reg  <= cneg_reg;
            job3_reg   <= job2_reg;

            // Stage 4: partial products of both sides of the cone compare.
            hh_reg      <= 36'(ad_reg[36:19]) * 36'(ad_reg[36:19]);
            hl_reg      <= 37'(ad_reg[36:19]) * 37'(ad_reg[18:0]);
            ll_reg      <= 38'(ad_reg[18:0]) * 38'(ad_reg[18:0]);
            rh_reg      <= 53'(d2_reg[41:21]) * 53'(c2_3_reg);
            rl_reg      <= 53'(d2_reg[20:0]) * 53'(c2_3_reg);
            cneg4_reg   <= cneg3_reg;
            far4_reg    <= far_reg;
            near4_reg   <= near_reg;
            dotneg4_reg <= dotneg_reg;
            job4_reg    <= job3_reg;

            // Stage 5: dot squared against distance squared times cosine squared.
            lhs_reg     <= {hh_reg, 38'd0} + 74'({hl_reg, 20'd0}) + 74'(ll_reg);
            rhs_reg     <= 74'({rh_reg, 21'd0}) + 74'(rl_reg);
            cneg5_reg   <= cneg4_reg;
            far5_reg    <= far4_reg;
            near5_reg   <= near4_reg;
            dotneg5_reg <= dotneg4_reg;
            job5_reg    <= job4_reg;
        end
    end

    // Visibility decision as the item enters the queue.
    assign ge = lhs_reg >= rhs_reg;
    assign le = lhs_reg <= rhs_reg;

    always_comb
    begin
        push_job     = job5_reg;
        push_job.vis = !far5_reg && (near5_reg ||
                       (cneg5_reg ? (!dotneg5_reg || le) : (!dotneg5_reg && ge)));
    end

endmodule

@@ sv/vcpm_queue.sv @@
// Short queue between the front pipeline and the table back end.
module vcpm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vcpm_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output vcpm_pkg::job_t pop_job,
    output logic           empty
);
    import vcpm_pkg::*;

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic              do_push, do_pop;

    assign full    = cnt_reg == (QPTR_W+1)'(QDEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = slot_reg[rd_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end

endmodule

@@ sv/vcpm_back.sv @@
// Back end: table read-modify-write, ageing and the confidence divider.
module vcpm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    output logic           q_pop,
    input  vcpm_pkg::job_t q_job,
    input  logic [15:0]    memory_ticks,
    input  logic           out_free,
    output logic           out_load,
    output vcpm_pkg::res_t out_res,
    output logic           clearing
);
    import vcpm_pkg::*;

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_CHECK, ST_DIV, ST_SEND} state_t;

    state_t            state_reg;
    logic [SLOT_W-1:0] clr_reg;
    job_t              job_reg;
    entry_t            ent_reg;
    logic [15:0]       r_reg;
    logic [16:0]       q_reg;
    logic [4:0]        step_reg;

    logic              ram_we, ram_re;
    logic [SLOT_W-1:0] ram_waddr;
    entry_t            ram_wdata, rd;
    logic [31:0]       age;
    logic              expired;
    logic [16:0]       t;
    logic              qbit;

    vcpm_ram #(.WIDTH($bits(entry_t)), .DEPTH(SLOTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (q_job.slot),
        .rdata (rd)
    );

    assign age     = job_reg.now - rd.seen;
    assign expired = age >= {16'd0, memory_ticks};
    assign clearing = state_reg == ST_CLEAR;

    // One restoring division step per cycle; the first step has no shift.
    assign t    = (step_reg == '0) ? {1'b0, r_reg} : {r_reg, 1'b0};
    assign qbit = t >= {1'b0, memory_ticks};

    // Table port, queue pop and result selection.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = job_reg.slot;
        ram_wdata = '0;
        q_pop     = 1'b0;
        out_load  = 1'b0;
        out_res.ent  = job_reg.ent;
        out_res.x    = job_reg.ex;
        out_res.y    = job_reg.ey;
        out_res.sx   = job_reg.sx;
        out_res.sy   = job_reg.sy;
        out_res.conf = CONF_ONE;
        out_res.seen = job_reg.now;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
            end
            ST_IDLE:
            begin
                q_pop  = !q_empty;
                ram_re = !q_empty;
            end
            ST_CHECK:
            begin
                if (job_reg.ok && job_reg.vis)
                begin
                    ram_we   = out_free;
                    out_load = out_free;
                    ram_wdata = {1'b1, job_reg.ey, job_reg.ex, job_reg.sy, job_reg.sx,
                                 job_reg.now};
                end
                else if (job_reg.ok && rd.valid && expired)
                begin
                    ram_we = 1'b1;
                end
            end
            ST_DIV:
            begin
            end
            ST_SEND:
            begin
                out_load     = out_free;
                out_res.x    = ent_reg.px;
                out_res.y    = ent_reg.py;
                out_res.sx   = ent_reg.sx;
                out_res.sy   = ent_reg.sy;
                out_res.conf = q_reg;
                out_res.seen = ent_reg.seen;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SLOT_W'(SLOTS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (!job_reg.ok)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (job_reg.vis)
                    begin
                        if (out_free)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else if (!rd.valid || expired)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_SEND;
                    end
                end
                ST_SEND:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Item, remembered entry and divider datapath.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && !q_empty)
        begin
            job_reg <= q_job;
        end
        if (state_reg == ST_CHECK)
        begin
            ent_reg <= rd;
            r_reg   <= memory_ticks - age[15:0];
            q_reg   <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            r_reg <= qbit ? 16'(t - {1'b0, memory_ticks}) : t[15:0];
            q_reg <= {q_reg[15:0], qbit};
        end
    end

endmodule

@@ sv/vision_cone_perception_memory.sv @@
// Vision cone perception memory: top level with configuration and output registers.
// Path: a seen entity reaches the output register through the front pipeline, the
// queue and the table check; a remembered one also passes the 17-step confidence divider.
// The back end takes one item at a time through a table read and write-back; a
// remembered entity also holds it through the divider and the send state.
// Reset: configuration returns to its defaults; then a clearing pass over the
// memory table runs, with s_axis_tready low throughout.
module vision_cone_perception_memory (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // observer_index, entity_index, observer_x, observer_y, facing_x, facing_y,
    // entity_x, entity_y, speed_x, speed_y, now_tick, zero fill
    input  logic [vcpm_pkg::IN_W-1:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_entity, out_x, out_y, out_speed_x, out_speed_y, confidence, seen_tick,
    // zero fill
    output logic [vcpm_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import vcpm_pkg::*;

    cfg_t              cfg_reg;
    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg;

    logic push, q_full, q_empty, q_pop, hold, out_free, out_load;
    job_t push_job, q_job;
    res_t out_res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.view_distance    <= 20'd3200;
            cfg_reg.awareness_radius <= 20'd192;
            cfg_reg.cone_cosine      <= '0;
            cfg_reg.memory_ticks     <= 16'd120;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VIEW_DISTANCE:    cfg_reg.view_distance    <= cfg_data;
                REG_AWARENESS_RADIUS: cfg_reg.awareness_radius <= cfg_data;
                REG_CONE_COSINE:      cfg_reg.cone_cosine      <= cfg_data[15:0];
                REG_MEMORY_TICKS:     cfg_reg.memory_ticks     <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    vcpm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .cfg      (cfg_reg),
        .hold     (hold),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    vcpm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_job),
        .empty    (q_empty)
    );

    vcpm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_job        (q_job),
        .memory_ticks (cfg_reg.memory_ticks),
        .out_free     (out_free),
        .out_load     (out_load),
        .out_res      (out_res),
        .clearing     (hold)
    );

    // Output register.
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_valid_reg <= out_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && out_free)
        begin
            m_data_reg <= {2'b00, out_res.seen, out_res.conf, out_res.sy, out_res.sx,
                           out_res.y, out_res.x, out_res.ent};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

@@ sv/vcpm_checker.sv @@
// Port-level checker for the vision cone perception memory, bound to the top level.
module vcpm_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata
);

    // A stalled result request keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Confidence never exceeds one.
    a_conf_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[101:85] <= 17'h10000)
        else $error("confidence above one");

    // Every reported entity, seen or remembered, keeps some confidence.
    a_conf_nz: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[101:85] != 17'd0)
        else $error("zero confidence reported");

    // The fill bits above the fields stay clear.
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[135:134] == 2'b00)
        else $error("fill bits set");

endmodule

bind vision_cone_perception_memory vcpm_checker u_vcpm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
